### design/ilp_pkg.sv
// Shared types and character constants for the integer literal parser.
`default_nettype none

package ilp_pkg;

  typedef enum logic [5:0] {
    MODE_START    = 6'b000001,
    MODE_ZERO     = 6'b000010,
    MODE_OCT      = 6'b000100,
    MODE_HEX      = 6'b001000,
    MODE_DEC      = 6'b010000,
    MODE_DEC_STOP = 6'b100000
  } mode_t;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HEX = 2'd2
  } radix_t;

  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [7:0] CHAR_LX    = 8'h78;
  localparam logic [7:0] CHAR_UX    = 8'h58;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  localparam logic [3:0] HEX_LETTER_OFFSET = 4'd9;
  localparam int         NUMBER_WIDTH      = 32;

endpackage

`default_nettype wire

### design/ilp_step.sv
// Combinational next-state and result logic for one character of the literal.
`default_nettype none

module ilp_step #(
  parameter int VALUE_WIDTH = 32
) (
  input  ilp_pkg::mode_t                mode,
  input  logic [VALUE_WIDTH-1:0]        acc,
  input  logic                          neg,
  input  logic [7:0]                    symbol,
  input  logic                          last_symbol,
  output ilp_pkg::mode_t                mode_next,
  output logic [VALUE_WIDTH-1:0]        acc_next,
  output logic                          neg_next,
  output logic signed [ilp_pkg::NUMBER_WIDTH-1:0] number,
  output ilp_pkg::radix_t               radix_kind
);
  import ilp_pkg::*;

  logic                   is_dec;
  logic                   is_lhex;
  logic                   is_uhex;
  logic [3:0]             hex_nib;
  logic [VALUE_WIDTH-1:0] oct_acc;
  logic [VALUE_WIDTH-1:0] hex_acc;
  logic [VALUE_WIDTH-1:0] dec_acc;
  mode_t                  mode_fed;
  logic [VALUE_WIDTH-1:0] acc_fed;
  logic                   neg_fed;
  logic [VALUE_WIDTH-1:0] value;

  assign is_dec  = (symbol >= CHAR_0) && (symbol <= CHAR_9);
  assign is_lhex = (symbol >= CHAR_LA) && (symbol <= CHAR_LF);
  assign is_uhex = (symbol >= CHAR_UA) && (symbol <= CHAR_UF);
  assign hex_nib = is_dec ? symbol[3:0] : symbol[3:0] + HEX_LETTER_OFFSET;

  assign oct_acc = (acc << 3) | (VALUE_WIDTH'(symbol) - VALUE_WIDTH'(CHAR_0));
  assign hex_acc = (acc << 4) | VALUE_WIDTH'(hex_nib);
  assign dec_acc = (acc << 3) + (acc << 1) + VALUE_WIDTH'(symbol[3:0]);

  always_comb begin
    mode_fed = mode;
    acc_fed  = acc;
    neg_fed  = neg;
    unique case (mode)
      MODE_START: begin
        if (symbol == CHAR_0) begin
          mode_fed = MODE_ZERO;
        end else if (symbol == CHAR_MINUS) begin
          neg_fed  = 1'b1;
          mode_fed = MODE_DEC;
        end else if (is_dec) begin
          mode_fed = MODE_DEC;
          acc_fed  = dec_acc;
        end else begin
          mode_fed = MODE_DEC_STOP;
        end
      end
      MODE_ZERO: begin
        if ((symbol == CHAR_LX) || (symbol == CHAR_UX)) begin
          mode_fed = MODE_HEX;
        end else begin
          mode_fed = MODE_OCT;
          acc_fed  = oct_acc;
        end
      end
      MODE_OCT: begin
        acc_fed = oct_acc;
      end
      MODE_HEX: begin
        if (is_dec || is_lhex || is_uhex) begin
          acc_fed = hex_acc;
        end
      end
      MODE_DEC: begin
        if (is_dec) begin
          acc_fed = dec_acc;
        end else begin
          mode_fed = MODE_DEC_STOP;
        end
      end
      MODE_DEC_STOP: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    priority if ((mode_fed == MODE_ZERO) || (mode_fed == MODE_OCT)) begin
      radix_kind = RADIX_OCT;
    end else if (mode_fed == MODE_HEX) begin
      radix_kind = RADIX_HEX;
    end else begin
      radix_kind = RADIX_DEC;
    end
  end

  assign value = neg_fed ? (~acc_fed + VALUE_WIDTH'(1)) : acc_fed;

  generate
    if (VALUE_WIDTH >= NUMBER_WIDTH) begin : g_trunc
      assign number = value[NUMBER_WIDTH-1:0];
    end else begin : g_zext
      assign number = {{(NUMBER_WIDTH-VALUE_WIDTH){1'b0}}, value};
    end
  endgenerate

  assign mode_next = last_symbol ? MODE_START : mode_fed;
  assign acc_next  = last_symbol ? '0 : acc_fed;
  assign neg_next  = last_symbol ? 1'b0 : neg_fed;

endmodule

`default_nettype wire

### design/integer_literal_parser_unit.sv
// Top level of the integer literal parser: parse state and result register.
// The result is registered and appears in the cycle after its last character is accepted.
// Throughput: one character per cycle while symbol_ready is high; shift-add is combinational.
// A character is taken whenever the result register is empty or being emptied.
// Reset (synchronous, active high) returns to the start mode with a zero
// accumulator and sign, and drops any pending result.
`default_nettype none

module integer_literal_parser_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    symbol_valid,
  output logic                                    symbol_ready,
  input  logic [7:0]                              symbol,
  input  logic                                    last_symbol,
  output logic                                    result_valid,
  input  logic                                    result_ready,
  output logic signed [ilp_pkg::NUMBER_WIDTH-1:0] number,
  output logic [1:0]                              radix_kind
);
  import ilp_pkg::*;

  mode_t                          mode;
  mode_t                          mode_next;
  logic [VALUE_WIDTH-1:0]         acc;
  logic [VALUE_WIDTH-1:0]         acc_next;
  logic                           neg;
  logic                           neg_next;
  logic signed [NUMBER_WIDTH-1:0] number_next;
  radix_t                         radix_next;
  logic                           accept;

  assign symbol_ready = !result_valid || result_ready;
  assign accept       = symbol_valid && symbol_ready;

  ilp_step #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_step (
    .mode        (mode),
    .acc         (acc),
    .neg         (neg),
    .symbol      (symbol),
    .last_symbol (last_symbol),
    .mode_next   (mode_next),
    .acc_next    (acc_next),
    .neg_next    (neg_next),
    .number      (number_next),
    .radix_kind  (radix_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_START;
      acc  <= '0;
      neg  <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      acc  <= acc_next;
      neg  <= neg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && last_symbol) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_symbol) begin
      number     <= number_next;
      radix_kind <= radix_next;
    end
  end

endmodule

`default_nettype wire

### dv/integer_literal_parser_unit_tb.sv
// Self-checking testbench for the integer literal parser with a scoreboard class.
`default_nettype none

module integer_literal_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ilp_pkg::*;

  localparam int ITEM_TARGET = 1800;
  localparam int CALM_TAIL   = 300;
  localparam int CYCLE_LIMIT = 200000;

  class literal_scoreboard;
    mode_t       mode;
    logic [31:0] acc;
    logic        neg;
    logic [31:0] number_q[$];
    radix_t      radix_q[$];
    int          errors;

    function new();
      errors = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      mode = MODE_START;
      acc  = '0;
      neg  = 1'b0;
    endfunction

    function void fold_decimal(logic [7:0] c);
      if (c >= CHAR_0 && c <= CHAR_9) begin
        acc = acc * 32'd10 + {24'b0, c - CHAR_0};
      end else begin
        mode = MODE_DEC_STOP;
      end
    endfunction

    function void fold_octal(logic [7:0] c);
      acc = (acc << 3) | ({24'b0, c} - 32'd48);
    endfunction

    function void fold_hex(logic [7:0] c);
      logic [3:0] nibble;
      logic       is_digit;
      is_digit = 1'b1;
      nibble   = '0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
        nibble = 4'(c - CHAR_0);
      end else if (c >= CHAR_LA && c <= CHAR_LF) begin
        nibble = 4'(c - CHAR_LA + 8'd10);
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
        nibble = 4'(c - CHAR_UA + 8'd10);
      end else begin
        is_digit = 1'b0;
      end
      if (is_digit) begin
        acc = (acc << 4) | {28'b0, nibble};
      end
    endfunction

    function void note_symbol(logic [7:0] c, logic last);
      radix_t radix;
      case (mode)
        MODE_START: begin
          if (c == CHAR_0) begin
            mode = MODE_ZERO;
          end else if (c == CHAR_MINUS) begin
            neg  = 1'b1;
            mode = MODE_DEC;
          end else begin
            mode = MODE_DEC;
            fold_decimal(c);
          end
        end
        MODE_ZERO: begin
          if (c == CHAR_LX || c == CHAR_UX) begin
            mode = MODE_HEX;
          end else begin
            mode = MODE_OCT;
            fold_octal(c);
          end
        end
        MODE_OCT: fold_octal(c);
        MODE_HEX: fold_hex(c);
        MODE_DEC: fold_decimal(c);
        default: ;
      endcase
      if (last) begin
        if (mode == MODE_ZERO || mode == MODE_OCT) begin
          radix = RADIX_OCT;
        end else if (mode == MODE_HEX) begin
          radix = RADIX_HEX;
        end else begin
          radix = RADIX_DEC;
        end
        number_q.push_back(neg ? -acc : acc);
        radix_q.push_back(radix);
        clear_parse();
      end
    endfunction

    task report(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [31:0] num, logic [1:0] radix);
      logic [31:0] want_num;
      radix_t      want_radix;
      if (number_q.size() == 0) begin
        report($sformatf("result with none pending: number %h radix %0d", num, radix));
      end else begin
        want_num   = number_q.pop_front();
        want_radix = radix_q.pop_front();
        if (num !== want_num) begin
          report($sformatf("number %h, want %h", num, want_num));
        end
        if (radix !== want_radix) begin
          report($sformatf("radix_kind %0d, want %0d", radix, want_radix));
        end
      end
    endtask

    function int pending();
      return number_q.size();
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           symbol_valid;
  logic                           symbol_ready;
  logic [7:0]                     symbol;
  logic                           last_symbol;
  logic                           result_valid;
  logic                           result_ready;
  logic signed [NUMBER_WIDTH-1:0] number;
  logic [1:0]                     radix_kind;

  literal_scoreboard sb;
  logic [7:0]        literal_q[$];
  bit                idle_on;
  int                items_sent;
  int                cycles;
  int                stall_left;

  integer_literal_parser_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .symbol_valid (symbol_valid),
    .symbol_ready (symbol_ready),
    .symbol       (symbol),
    .last_symbol  (last_symbol),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .number       (number),
    .radix_kind   (radix_kind)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) begin
        sb.check_result(number, radix_kind);
      end
      if (symbol_valid && symbol_ready) begin
        sb.note_symbol(symbol, last_symbol);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    result_ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7);
      end
      if (stall_left > 0) begin
        result_ready <= 1'b0;
        stall_left--;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  task automatic send_symbol(logic [7:0] c, logic last);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      symbol_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    symbol_valid <= 1'b1;
    symbol       <= c;
    last_symbol  <= last;
    @(posedge clk);
    while (!symbol_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_literal();
    for (int i = 0; i < literal_q.size(); i++) begin
      send_symbol(literal_q[i], i == literal_q.size() - 1);
    end
    literal_q.delete();
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      literal_q.push_back(s[i]);
    end
    send_literal();
  endtask

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] rand_hex_char();
    case ($urandom_range(0, 2))
      0: return CHAR_0 + 8'($urandom_range(0, 9));
      1: return CHAR_LA + 8'($urandom_range(0, 5));
      default: return CHAR_UA + 8'($urandom_range(0, 5));
    endcase
  endfunction

  task automatic build_random_literal();
    int len;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        if ($urandom_range(0, 1)) literal_q.push_back(CHAR_MINUS);
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          literal_q.push_back(($urandom_range(0, 9) == 0) ? rand_byte()
                                                          : CHAR_0 + 8'($urandom_range(0, 9)));
        end
      end
      3, 4: begin
        literal_q.push_back(CHAR_0);
        literal_q.push_back($urandom_range(0, 1) ? CHAR_LX : CHAR_UX);
        len = $urandom_range(0, 10);
        for (int i = 0; i < len; i++) begin
          literal_q.push_back(($urandom_range(0, 7) == 0) ? rand_byte() : rand_hex_char());
        end
      end
      5, 6: begin
        literal_q.push_back(CHAR_0);
        len = $urandom_range(0, 13);
        for (int i = 0; i < len; i++) begin
          literal_q.push_back(($urandom_range(0, 7) == 0) ? rand_byte()
                                                          : CHAR_0 + 8'($urandom_range(0, 7)));
        end
      end
      7: begin
        case ($urandom_range(0, 2))
          0: literal_q.push_back(CHAR_0);
          1: literal_q.push_back(CHAR_MINUS);
          default: begin
            literal_q.push_back(CHAR_0);
            literal_q.push_back(CHAR_LX);
          end
        endcase
      end
      default: begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          literal_q.push_back(rand_byte());
        end
      end
    endcase
  endtask

  initial begin
    int literal_count;
    sb            = new();
    rst           = 1'b1;
    symbol_valid  = 1'b0;
    symbol        = '0;
    last_symbol   = 1'b0;
    idle_on       = 1'b0;
    items_sent    = 0;
    cycles        = 0;
    literal_count = 0;
    repeat (10) @(negedge clk);
    rst     <= 1'b0;
    idle_on = 1'b1;
    @(negedge clk);

    send_text("0");
    send_text("0x");
    send_text("0X");
    send_text("-");
    send_text("-5-7");
    send_text("9");
    send_text("0xfF");
    send_text("0xG");
    literal_q.push_back(CHAR_0);
    literal_q.push_back(8'h00);
    send_literal();
    literal_q.push_back(8'h00);
    send_literal();
    literal_q.push_back(8'hFF);
    send_literal();

    while (items_sent < ITEM_TARGET) begin
      if (items_sent > ITEM_TARGET - CALM_TAIL) idle_on = 1'b0;
      build_random_literal();
      send_literal();
      literal_count++;
      if (literal_count % 40 == 0) begin
        symbol_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
      end
    end

    symbol_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    end
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
